// File: hw/rtl/rtrh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtrh_pkg : shared constants and types for the ripple height pipeline
// Widths of the datapath, register indexes and the root stage sideband struct.
// ----------------------------------------------------------------------------
package rtrh_pkg;

  localparam int SqW    = 35;              // sum of squares, Q14.20
  localparam int DistW  = 18;              // floor(sqrt), Q7.10
  localparam int SqStep = DistW;           // one root bit per stage
  localparam int DivQW  = 17;              // gain quotient bits (0..65536)
  localparam int DenW   = 34;              // 2^26 + rate*d

  typedef enum logic [2:0] {
    REG_AMPLITUDE  = 3'd0,
    REG_INV_WAVE   = 3'd1,
    REG_INV_PERIOD = 3'd2,
    REG_ATTEN      = 3'd3,
    REG_SOURCE_X   = 3'd4,
    REG_SOURCE_Z   = 3'd5
  } reg_idx_t;

  // root stage carry: remainder, partial root, time context
  typedef struct packed {
    logic              vld;
    logic [SqW-1:0]    rem;
    logic [DistW-1:0]  root;
    logic [31:0]       tm;
  } sq_beat_t;

endpackage

// File: hw/rtl/rtrh_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtrh_sqrt : pipelined integer square root
// Restoring root, one result bit per register stage; time rides along.
// ----------------------------------------------------------------------------
module rtrh_sqrt
  import rtrh_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_vld,
  input  logic [SqW-1:0]   in_sq,
  input  logic [31:0]      in_tm,
  output logic             out_vld,
  output logic [DistW-1:0] out_root,
  output logic [31:0]      out_tm
);

  sq_beat_t stg [SqStep+1];

  always_comb begin
    stg[0].vld  = in_vld;
    stg[0].rem  = in_sq;
    stg[0].root = '0;
    stg[0].tm   = in_tm;
  end

  for (genvar i = 0; i < SqStep; i++) begin : g_bit
    localparam int Sh = 2 * (SqStep - 1 - i);
    logic [SqW+1:0] trial;
    logic [SqW+1:0] rem_hi;
    sq_beat_t       nxt;
    always_comb begin
      // test (4*root+1) << Sh against remainder
      trial  = ({{(SqW+2-DistW){1'b0}}, stg[i].root} << (Sh + 2))
               | ((SqW+2)'(1) << Sh);
      rem_hi = {2'b00, stg[i].rem};
      nxt    = stg[i];
      if (rem_hi >= trial) begin
        nxt.rem  = SqW'(rem_hi - trial);
        nxt.root = {stg[i].root[DistW-2:0], 1'b1};
      end else begin
        nxt.root = {stg[i].root[DistW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        stg[i+1].vld <= 1'b0;
      end else begin
        stg[i+1].vld <= nxt.vld;
      end
      stg[i+1].rem  <= nxt.rem;
      stg[i+1].root <= nxt.root;
      stg[i+1].tm   <= nxt.tm;
    end
  end

  assign out_vld  = stg[SqStep].vld;
  assign out_root = stg[SqStep].root;
  assign out_tm   = stg[SqStep].tm;

endmodule

// File: hw/rtl/rtrh_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtrh_div : pipelined gain divider
// Computes floor(2^42 / den), one quotient bit per stage, with a sideband.
// ----------------------------------------------------------------------------
module rtrh_div
  import rtrh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_vld,
  input  logic [DenW-1:0]   in_den,
  input  logic [17:0]       in_side,
  output logic              out_vld,
  output logic [DivQW-1:0]  out_q,
  output logic [17:0]       out_side
);

  // den >= 2^26 so quotient < 2^17; start with remainder 2^42 >> 17 = 2^25
  localparam int RemW = DenW + 1;

  logic              vld  [DivQW+1];
  logic [RemW-1:0]   rem  [DivQW+1];
  logic [DivQW-1:0]  quo  [DivQW+1];
  logic [DenW-1:0]   den  [DivQW+1];
  logic [17:0]       side [DivQW+1];

  always_comb begin
    vld[0]  = in_vld;
    rem[0]  = RemW'(1) << 25;
    quo[0]  = '0;
    den[0]  = in_den;
    side[0] = in_side;
  end

  for (genvar i = 0; i < DivQW; i++) begin : g_bit
    logic [RemW-1:0] sh;
    logic            take;
    // the dividend's low bits are all zero, so shift in zeros
    always_comb begin
      sh   = {rem[i][RemW-2:0], 1'b0};
      take = sh >= {1'b0, den[i]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      rem[i+1]  <= take ? sh - {1'b0, den[i]} : sh;
      quo[i+1]  <= {quo[i][DivQW-2:0], take};
      den[i+1]  <= den[i];
      side[i+1] <= side[i];
    end
  end

  assign out_vld  = vld[DivQW];
  assign out_q    = quo[DivQW];
  assign out_side = side[DivQW];

endmodule

// File: hw/rtl/radial_triangle_ripple_height.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_triangle_ripple_height : radial triangle-wave ripple height
// Distance from a source, triangle wave of the ripple phase, distance damping.
// ----------------------------------------------------------------------------
// Pipeline from start to done: root 18 stages, divider 17 stages and
// 9 stages of arithmetic. Throughput: one point per cycle, set by the
// one-bit-per-stage root and divider pipelines. Results cannot be stalled.
// Reset clears all valid bits and loads the register defaults.
module radial_triangle_ripple_height
  import rtrh_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_z,
  input  logic [31:0]        time_now,
  output logic               done,
  output logic signed [15:0] height,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [15:0]        cfg_data
);

  logic [15:0]        amplitude, inv_wavelength, inv_period, attenuation_rate;
  logic signed [15:0] source_x, source_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude        <= 16'd1843;
      inv_wavelength   <= 16'd1024;
      inv_period       <= 16'd2560;
      attenuation_rate <= 16'd5243;
      source_x         <= '0;
      source_z         <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_AMPLITUDE:  amplitude        <= cfg_data;
        REG_INV_WAVE:   inv_wavelength   <= cfg_data;
        REG_INV_PERIOD: inv_period       <= cfg_data;
        REG_ATTEN:      attenuation_rate <= cfg_data;
        REG_SOURCE_X:   source_x         <= cfg_data;
        REG_SOURCE_Z:   source_z         <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;
  logic acc;
  assign acc = start && !busy;

  // stage 1: differences
  logic               v1;
  logic signed [16:0] dx1, dz1;
  logic [31:0]        tm1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= acc;
    dx1 <= 17'(point_x) - 17'(source_x);
    dz1 <= 17'(point_z) - 17'(source_z);
    tm1 <= time_now;
  end

  // stage 2: squares
  logic        v2;
  logic [33:0] sx2, sz2;
  logic [31:0] tm2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    sx2 <= 34'(dx1 * dx1);
    sz2 <= 34'(dz1 * dz1);
    tm2 <= tm1;
  end

  // stage 3: sum
  logic           v3;
  logic [SqW-1:0] s3;
  logic [31:0]    tm3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
    s3  <= SqW'(sx2) + SqW'(sz2);
    tm3 <= tm2;
  end

  logic             vr;
  logic [DistW-1:0] dr;
  logic [31:0]      tmr;
  rtrh_sqrt u_sqrt (
    .clk(clk), .rst(rst), .in_vld(v3), .in_sq(s3), .in_tm(tm3),
    .out_vld(vr), .out_root(dr), .out_tm(tmr)
  );

  // stage 4: products for phase and damping
  logic        v4;
  logic [33:0] dw4, ad4;
  logic [47:0] tp4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= vr;
    dw4 <= 34'(dr) * 34'(inv_wavelength);
    ad4 <= 34'(dr) * 34'(attenuation_rate);
    tp4 <= 48'(tmr) * 48'(inv_period);
  end

  // stage 5: phase fraction -> wave; damping denominator
  logic        v5;
  logic [15:0] t5;
  logic [DenW-1:0] den5;
  logic [27:0] ph5;
  always_comb ph5 = 28'({dw4, 6'b0}) - tp4[27:0];
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else     v5 <= v4;
    t5   <= ph5[27:12];
    den5 <= DenW'(ad4) + (DenW'(1) << 26);
  end

  // triangle wave: magnitude and sign, 17 bits
  logic        neg5;
  logic [16:0] wm5;
  logic [17:0] t4x;
  always_comb begin
    t4x = {t5, 2'b00};
    if (!t5[15]) begin
      neg5 = t4x < 18'd65536;
      wm5  = neg5 ? 17'(18'd65536 - t4x) : 17'(t4x - 18'd65536);
    end else begin
      neg5 = t4x > 18'd196608;
      wm5  = neg5 ? 17'(t4x - 18'd196608) : 17'(18'd196608 - t4x);
    end
  end

  logic             vg;
  logic [DivQW-1:0] g;
  logic [17:0]      sidg;
  rtrh_div u_div (
    .clk(clk), .rst(rst), .in_vld(v5), .in_den(den5), .in_side({neg5, wm5}),
    .out_vld(vg), .out_q(g), .out_side(sidg)
  );

  // stage 6: amplitude * gain
  logic        v6, neg6;
  logic [32:0] ag6;
  logic [16:0] wm6;
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else     v6 <= vg;
    ag6  <= 33'(amplitude) * 33'(g);
    wm6  <= sidg[16:0];
    neg6 <= sidg[17];
  end

  // stage 7: times wave, split: low and high halves of wave
  logic        v7, neg7;
  logic [41:0] lo7;
  logic [41:0] hi7;
  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else     v7 <= v6;
    lo7  <= 42'(ag6) * 42'(wm6[8:0]);
    hi7  <= 42'(ag6) * 42'(wm6[16:9]);
    neg7 <= neg6;
  end

  // stage 8: combine, round
  logic        v8, neg8;
  logic [18:0] mag8;
  logic [50:0] full7;
  always_comb full7 = 51'(lo7) + (51'(hi7) << 9) + (51'd1 << 31);
  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else     v8 <= v7;
    mag8 <= full7[50:32];
    neg8 <= neg7;
  end

  // stage 9: saturate
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= v8;
    if (neg8)
      height <= (mag8 > 19'd32768) ? -16'sd32768 : 16'(-$signed({1'b0, mag8}));
    else
      height <= (mag8 > 19'd32767) ? 16'sd32767 : 16'(mag8);
  end

  a_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");
  a_done_lat: assert property (@(posedge clk) disable iff (rst)
    v8 |=> done) else $error("done lost");
  a_v4: assert property (@(posedge clk) disable iff (rst)
    vr |=> v4) else $error("root beat lost");
  a_gain: assert property (@(posedge clk) disable iff (rst)
    vg |-> g <= 17'd65536) else $error("gain over unity");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench : self-checking bench for radial_triangle_ripple_height
// Drives directed query points and random bursts across several register settings.
// Predicts each height in fixed point and compares it with every done beat.
// ----------------------------------------------------------------------------
module testbench;
  import rtrh_pkg::*;

  localparam logic [2:0] IDX_SPARE_LO = 3'd6;   // outside the register map
  localparam logic [2:0] IDX_SPARE_HI = 3'd7;
  localparam int PIPE_LAT   = 44;
  localparam int SETTLE     = PIPE_LAT + 10;
  localparam int STALL_MAX  = 4000;
  localparam int RAND_ITEMS = 1100;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic signed [15:0] point_x;
  logic signed [15:0] point_z;
  logic [31:0]        time_now;
  logic               done;
  logic signed [15:0] height;
  logic               cfg_we;
  logic [2:0]         cfg_idx;
  logic [15:0]        cfg_data;

  // shadow registers
  logic [15:0]        amp_q;
  logic [15:0]        inv_wave_q;
  logic [15:0]        inv_per_q;
  logic [15:0]        atten_q;
  logic signed [15:0] src_x_q;
  logic signed [15:0] src_z_q;

  logic signed [15:0] height_pending[$];
  int                 mismatches;
  int                 idle_cycles;
  logic               accept_seen;

  radial_triangle_ripple_height DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .point_x(point_x), .point_z(point_z), .time_now(time_now),
    .done(done), .height(height),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [15:0] ripple_height(logic signed [15:0] px,
                                                       logic signed [15:0] pz,
                                                       logic [31:0] tm);
    longint signed   dx;
    longint signed   dz;
    longint unsigned sq;
    longint unsigned root;
    longint unsigned probe;
    longint unsigned phase;
    longint unsigned frac;
    longint unsigned wmag;
    longint unsigned gain;
    longint unsigned mag;
    logic            neg;
    dx = longint'(px) - longint'(src_x_q);
    dz = longint'(pz) - longint'(src_z_q);
    sq = longint'(dx * dx) + longint'(dz * dz);
    root = 0;
    probe = 64'd1 << 62;
    while (probe > sq) probe = probe >> 2;
    while (probe != 0) begin
      if (sq >= root + probe) begin
        sq = sq - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    phase = ((root * inv_wave_q) << 6) - 64'(tm) * inv_per_q;
    phase = phase & ((64'd1 << 28) - 1);
    frac = phase >> 12;
    if (frac < 32768) begin
      neg = (frac * 4) < 65536;
      wmag = neg ? 65536 - frac * 4 : frac * 4 - 65536;
    end else begin
      neg = (frac * 4) > 196608;
      wmag = neg ? frac * 4 - 196608 : 196608 - frac * 4;
    end
    gain = (64'd1 << 42) / ((64'd1 << 26) + 64'(atten_q) * root);
    mag = (64'(amp_q) * gain * wmag + (64'd1 << 31)) >> 32;
    if (neg) return (mag > 32768) ? -16'sd32768 : -16'(mag);
    return (mag > 32767) ? 16'sd32767 : 16'(mag);
  endfunction

  // check each done beat against the oldest prediction
  always @(posedge clk) begin
    logic signed [15:0] want;
    if (!rst && done) begin
      if (height_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected done beat, height %0d", height);
      end else begin
        want = height_pending.pop_front();
        if (height !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("height mismatch: expected %0d, got %0d", want, height);
        end
      end
    end
  end

  // watchdog on cycles with no beat in either direction
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_MAX) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_point(logic signed [15:0] px, logic signed [15:0] pz,
                            logic [31:0] tm);
    accept_seen = 1'b0;
    point_x = px;
    point_z = pz;
    time_now = tm;
    start = 1'b1;
    while (!accept_seen) begin
      @(posedge clk);
      if (!busy) begin
        accept_seen = 1'b1;
        height_pending = {height_pending, ripple_height(px, pz, tm)};
      end
      @(negedge clk);
    end
  endtask

  task automatic pause_sender(int cycles);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // drain the pipeline before touching registers
  task automatic wait_idle();
    start = 1'b0;
    while (height_pending.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_AMPLITUDE:  amp_q = val;
      REG_INV_WAVE:   inv_wave_q = val;
      REG_INV_PERIOD: inv_per_q = val;
      REG_ATTEN:      atten_q = val;
      REG_SOURCE_X:   src_x_q = val;
      REG_SOURCE_Z:   src_z_q = val;
      default: ;
    endcase
  endtask

  task automatic write_all(logic [15:0] amp, logic [15:0] iw, logic [15:0] ip,
                           logic [15:0] att, logic [15:0] sx, logic [15:0] sz);
    wait_idle();
    write_reg(REG_AMPLITUDE, amp);
    write_reg(REG_INV_WAVE, iw);
    write_reg(REG_INV_PERIOD, ip);
    write_reg(REG_ATTEN, att);
    write_reg(REG_SOURCE_X, sx);
    write_reg(REG_SOURCE_Z, sz);
  endtask

  task automatic test_field_extremes();
    send_point(16'sh7FFF, 16'sh7FFF, 32'hFFFF_FFFF);
    send_point(-16'sh8000, -16'sh8000, 32'h0);
    send_point(16'sh7FFF, -16'sh8000, 32'h8000_0000);
    send_point(-16'sh8000, 16'sh7FFF, 32'h0000_FFFF);
    send_point(16'sh0, 16'sh0, 32'h0);
    send_point(16'sh0400, 16'sh0, 32'h0001_0000);
    send_point(16'sh0, -16'sh0400, 32'h5555_AAAA);
    send_point(16'shAAAA, 16'sh5555, 32'hAAAA_5555);
  endtask

  task automatic test_special_cases();
    // stationary wave in space, then stationary in time with no damping
    write_all(16'd1843, 16'd0, 16'd2560, 16'd5243, 16'h0, 16'h0);
    send_point(16'sh1234, -16'sh0F00, 32'h0003_4000);
    send_point(-16'sh7000, 16'sh7000, 32'h0003_4000);
    write_all(16'd1843, 16'd1024, 16'd0, 16'd0, 16'h0, 16'h0);
    send_point(16'sh1000, 16'sh0200, 32'h1234_5678);
    send_point(16'sh1000, 16'sh0200, 32'hFEDC_BA98);
    // saturation with full amplitude and unity gain
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'h7FFF, 16'h8000);
    send_point(16'sh7FFF, -16'sh8000, 32'h0);
    send_point(-16'sh8000, 16'sh7FFF, 32'h0000_4000);
    send_point(16'sh0, 16'sh0, 32'h0000_C000);
    // time wrap around the top of the counter
    write_all(16'd4096, 16'd1, 16'd4096, 16'hFFFF, 16'h8000, 16'h7FFF);
    send_point(16'sh0, 16'sh0, 32'hFFFF_FFFF);
    send_point(16'sh0, 16'sh0, 32'h0000_0000);
    // spare indexes must leave the map untouched
    wait_idle();
    write_reg(IDX_SPARE_LO, 16'hFFFF);
    write_reg(IDX_SPARE_HI, 16'h1234);
    send_point(16'sh0100, 16'sh0100, 32'h0000_8000);
  endtask

  task automatic test_random_bursts();
    int         sent;
    int         burst;
    int         gap;
    logic [15:0] px;
    logic [15:0] pz;
    logic [31:0] tm;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      if (sent % 220 == 0) begin
        write_all($urandom_range(3) == 0 ? 16'hFFFF : 16'($urandom),
                  $urandom_range(7) == 0 ? 16'd1 : 16'($urandom),
                  16'($urandom), $urandom_range(5) == 0 ? 16'd0 : 16'($urandom),
                  16'($urandom), 16'($urandom));
      end
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < RAND_ITEMS; k++) begin
        if ($urandom_range(3) == 0) begin
          // near the source, small distances
          px = src_x_q + 16'($signed(11'($urandom)));
          pz = src_z_q + 16'($signed(11'($urandom)));
        end else begin
          px = 16'($urandom);
          pz = 16'($urandom);
        end
        tm = ($urandom_range(7) == 0) ? {16'hFFFF, 16'($urandom)} : $urandom;
        send_point(px, pz, tm);
        sent++;
      end
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      pause_sender(gap);
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    point_x = '0;
    point_z = '0;
    time_now = '0;
    cfg_we = 1'b0;
    cfg_idx = REG_AMPLITUDE;
    cfg_data = '0;
    mismatches = 0;
    idle_cycles = 0;
    amp_q = 16'd1843;
    inv_wave_q = 16'd1024;
    inv_per_q = 16'd2560;
    atten_q = 16'd5243;
    src_x_q = '0;
    src_z_q = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_field_extremes();
    test_special_cases();
    test_random_bursts();
    wait_idle();
    if (mismatches == 0 && height_pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
